>>> src/first_fit_slot_allocator_macros.svh
// Assertion macros for the first-fit slot allocator.
`ifndef FIRST_FIT_SLOT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ffsa_pkg.sv
// Shared constants, types and codes for the first-fit slot allocator.
package ffsa_pkg;

	localparam int SLOTS   = 16;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int TAG_W   = 8;
	localparam int UNITS_W = 5;
	localparam int START_W = 4;
	localparam int STAT_W  = 2;
	localparam int CMP_W   = (UNITS_W > CNT_W) ? UNITS_W : CNT_W;

	localparam int S_FIELDS_W = TAG_W + UNITS_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = STAT_W + START_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_NO_HOLE = 2'd1,
		STAT_NO_RUN  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_HOLD
	} state_t;

	// controller to slot chain
	typedef struct packed {
		logic             shift;
		logic [TAG_W-1:0] wdata;
	} chain_ctl_t;

endpackage

>>> src/ffsa_cell.sv
// One slot of the rotating owner-tag chain.
module ffsa_cell
	import ffsa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [TAG_W-1:0] d,
	output logic [TAG_W-1:0] q
);

	logic [TAG_W-1:0] tag_q;

	// tag zero marks an empty slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (shift) begin
			tag_q <= d;
		end
	end

	assign q = tag_q;

endmodule

>>> src/ffsa_ctrl.sv
// Request sequencer: scan pass, fill/clear pass and result register.
module ffsa_ctrl
	import ffsa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [0:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic [TAG_W-1:0]     head,
	output chain_ctl_t           ctl,
	output state_t               state
);

	state_t             state_q, state_d;
	act_t               act_q;
	logic [TAG_W-1:0]   owner_q;
	logic [CNT_W-1:0]   units_q;
	logic [IDX_W-1:0]   j_q;
	logic [CNT_W-1:0]   run_q;
	logic [CNT_W-1:0]   base_q;
	logic [TAG_W-1:0]   prev_q;
	logic [TAG_W-1:0]   seek_q;
	logic               found_q;
	logic               started_q;
	logic [CNT_W-1:0]   rem_q;
	status_t            stat_q;
	logic [START_W-1:0] start_q;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	act_t             in_act;
	logic [TAG_W-1:0] in_owner;
	logic [UNITS_W-1:0] in_units;
	logic             in_big, in_zero, in_trivial;
	logic             accept, last, out_free, out_load;
	logic             empty, hit, found_n;
	logic [CNT_W-1:0] run_n;
	logic             start_now, wr;
	logic [TAG_W-1:0] fill_val;

	assign in_act   = act_t'(s_tuser[0]);
	assign in_owner = s_tdata[TAG_W-1:0];
	assign in_units = s_tdata[TAG_W+UNITS_W-1:TAG_W];
	assign in_big   = CMP_W'(in_units) > CMP_W'(SLOTS);
	assign in_zero  = in_units == '0;
	assign in_trivial = in_big || in_zero;

	assign last     = j_q == IDX_W'(SLOTS - 1);
	assign out_free = !m_tvalid_q || m_tready;
	assign empty    = head == '0;

	// run length at the head slot
	always_comb begin
		if (act_q == ACT_ALLOC) begin
			run_n = empty ? run_q + 1'b1 : '0;
			hit   = empty && (run_n == units_q);
		end else begin
			if (empty) begin
				run_n = '0;
			end else if (head == prev_q) begin
				run_n = run_q + 1'b1;
			end else begin
				run_n = CNT_W'(1);
			end
			hit = !empty && (run_n == units_q);
		end
	end

	assign found_n = found_q || hit;

	// fill/clear pass: allocate starts at base, free at first slot of the found owner
	assign start_now = !started_q &&
		((act_q == ACT_ALLOC) ? (CNT_W'(j_q) == base_q) : (head == seek_q));
	assign wr        = (start_now || started_q) && (rem_q != '0);
	assign fill_val  = (act_q == ACT_ALLOC) ? owner_q : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = in_trivial ? ST_HOLD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = found_n ? ST_FILL : ST_HOLD;
				end
			end
			ST_FILL: begin
				if (last) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		ctl.shift = 1'b0;
		ctl.wdata = head;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: ctl.shift = 1'b1;
			ST_FILL: begin
				ctl.shift = 1'b1;
				if (wr) begin
					ctl.wdata = fill_val;
				end
			end
			ST_HOLD: out_load = out_free;
			default: s_tready = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			j_q       <= '0;
			found_q   <= 1'b0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				j_q       <= '0;
				found_q   <= in_zero;
				started_q <= 1'b0;
			end else if (state_q == ST_SCAN || state_q == ST_FILL) begin
				j_q <= last ? '0 : j_q + 1'b1;
				if (state_q == ST_SCAN) begin
					found_q <= found_n;
				end else if (start_now) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= in_act;
			owner_q <= in_owner;
			units_q <= CNT_W'(in_units);
			run_q   <= '0;
			base_q  <= '0;
			prev_q  <= '0;
			start_q <= '0;
			if (in_big) begin
				stat_q <= (in_act == ACT_ALLOC) ? STAT_NO_HOLE : STAT_NO_RUN;
			end else begin
				stat_q <= STAT_DONE;
			end
		end else if (state_q == ST_SCAN) begin
			if (!found_q) begin
				run_q  <= run_n;
				prev_q <= head;
				if (act_q == ACT_ALLOC && !empty) begin
					base_q <= CNT_W'(j_q) + 1'b1;
				end
				if (hit) begin
					seek_q <= head;
				end
			end
			if (last) begin
				rem_q <= units_q;
				if (!found_n) begin
					stat_q <= (act_q == ACT_ALLOC) ? STAT_NO_HOLE : STAT_NO_RUN;
				end
			end
		end else if (state_q == ST_FILL) begin
			if (start_now) begin
				start_q <= START_W'(j_q);
			end
			if (wr) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= M_TDATA_W'({(stat_q == STAT_DONE) ? start_q : {START_W{1'b0}},
				stat_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign state    = state_q;

endmodule

>>> src/first_fit_slot_allocator.sv
// Top level: first-fit slot allocator built on a rotating chain of slot cells.
// Sequence: the chain rotates once to scan and once more to fill or clear;
//   no fit skips the fill/clear pass; zero units or units beyond the table skip both.
// Flow: a new word is taken only from idle, after the last result has loaded, and a
//   result not yet taken holds the sequencer.
// Reset: all slot tags clear to empty at once, no clearing pass; result register empties.
`include "first_fit_slot_allocator_macros.svh"

module first_fit_slot_allocator
	import ffsa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // owner[7:0], units[12:8], zero pad
	input  logic [0:0]           s_tuser,  // action[0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // status[1:0], start_slot[5:2], zero pad
);

	chain_ctl_t       ctl;
	state_t           state;
	logic [TAG_W-1:0] tag [SLOTS];

	// cell 0 is the head seen by the sequencer; write-back enters at the tail
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == SLOTS - 1) begin : g_tail
			ffsa_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (ctl.shift),
				.d     (ctl.wdata),
				.q     (tag[i])
			);
		end else begin : g_body
			ffsa_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (ctl.shift),
				.d     (tag[i+1]),
				.q     (tag[i])
			);
		end
	end

	ffsa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.head    (tag[0]),
		.ctl     (ctl),
		.state   (state)
	);

	`FFSA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`FFSA_ASSERT_NOW(a_no_shift_when_ready, ctl.shift, !s_tready, "chain moves while idle")
	`FFSA_ASSERT_NOW(a_hold_not_ready, state == ST_HOLD, !s_tready && !ctl.shift, "bad hold")
	`FFSA_ASSERT_NOW(a_err_start_zero, m_tvalid && m_tdata[1:0] != STAT_DONE,
		m_tdata[5:2] == '0, "start slot set on failed request")

endmodule

>>> tb/tb_first_fit_slot_allocator.sv
// Self-checking testbench for the first-fit slot allocator: directed and random requests.
`timescale 1ns / 100ps

module tb_first_fit_slot_allocator;
	import ffsa_pkg::*;

	localparam int STALL_LIMIT = 3000;

	typedef struct {
		status_t            status;
		logic [START_W-1:0] start;
	} grant_t;

	// Mirror of the slot table plus the queue of grants still owed by the block.
	class slot_ledger;
		logic [TAG_W-1:0] tag_of [SLOTS];
		grant_t           owed [$];
		int               errors;

		function new();
			foreach (tag_of[i])
				tag_of[i] = '0;
			errors = 0;
		endfunction

		function void note_request(act_t act, logic [TAG_W-1:0] owner,
				logic [UNITS_W-1:0] units);
			grant_t           g;
			int               n;
			int               i;
			int               run;
			int               base;
			int               first;
			logic [TAG_W-1:0] seek;
			n = units;
			g.status = STAT_DONE;
			g.start = '0;
			if (act == ACT_ALLOC) begin
				run = 0;
				base = 0;
				for (i = 0; i < SLOTS && run < n; i++) begin
					if (tag_of[i] == '0) begin
						run++;
					end else begin
						run = 0;
						base = i + 1;
					end
				end
				if (n > SLOTS || run != n) begin
					g.status = STAT_NO_HOLE;
				end else begin
					for (i = 0; i < n && base + i < SLOTS; i++)
						tag_of[base + i] = owner;
					g.start = base[START_W-1:0];
				end
			end else begin
				i = 0;
				run = 0;
				seek = tag_of[0];
				// an owner change restarts the run without advancing
				while (n <= SLOTS && i < SLOTS && run != n) begin
					if (tag_of[i] == '0) begin
						run = 0;
						i++;
					end else if (tag_of[i] == seek) begin
						run++;
						i++;
					end else begin
						seek = tag_of[i];
						run = 0;
					end
				end
				if (n > SLOTS || run != n) begin
					g.status = STAT_NO_RUN;
				end else begin
					// clear starts at the owner's lowest slot, which may precede the run
					first = 0;
					while (first < SLOTS && tag_of[first] != seek)
						first++;
					if (first >= SLOTS)
						first = 0;
					for (i = 0; i < n && first + i < SLOTS; i++)
						tag_of[first + i] = '0;
					g.start = first[START_W-1:0];
				end
			end
			owed.push_back(g);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] word);
			grant_t g;
			if (owed.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual status %0d start %0d",
					$time, word[STAT_W-1:0], word[STAT_W +: START_W]);
				errors++;
			end else begin
				g = owed.pop_front();
				if (word[STAT_W-1:0] !== g.status || word[STAT_W +: START_W] !== g.start) begin
					$display("%0t: mismatch, expected status %0d start %0d, actual status %0d start %0d",
						$time, g.status, g.start, word[STAT_W-1:0],
						word[STAT_W +: START_W]);
					errors++;
				end
			end
		endfunction

		// length of a random prefix of some owned run, 0 when the table is empty
		function int pick_run_units();
			int i;
			int len;
			int seen;
			int pick;
			seen = 0;
			pick = 0;
			i = 0;
			while (i < SLOTS) begin
				if (tag_of[i] == '0) begin
					i++;
				end else begin
					len = 1;
					while (i + len < SLOTS && tag_of[i + len] == tag_of[i])
						len++;
					seen++;
					if ($urandom_range(seen - 1) == 0)
						pick = len;
					i += len;
				end
			end
			return (pick == 0) ? 0 : $urandom_range(1, pick);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [0:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	slot_ledger ledger = new();
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         quiet_cycles = 0;

	first_fit_slot_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// word monitor and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				ledger.note_request(act_t'(s_tuser[0]), s_tdata[TAG_W-1:0],
					s_tdata[TAG_W +: UNITS_W]);
			if (m_tvalid && m_tready)
				ledger.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL first_fit_slot_allocator");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	task automatic send_word(act_t act, logic [TAG_W-1:0] owner, logic [UNITS_W-1:0] units);
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, units, owner};
		s_tuser <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic sender_pause();
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_request();
		int               roll;
		int               n;
		int               run_units;
		logic [TAG_W-1:0] owner;
		roll = $urandom_range(99);
		// a small owner pool makes neighboring blocks share tags
		owner = ($urandom_range(3) == 0) ? TAG_W'($urandom_range(1, 255))
			: TAG_W'($urandom_range(1, 6));
		if ($urandom_range(49) == 0)
			owner = '0;
		if (roll < 3)
			n = $urandom_range(SLOTS + 1, 31);
		else if (roll < 6)
			n = 0;
		else if (roll < 12)
			n = $urandom_range(6, SLOTS);
		else
			n = $urandom_range(1, 5);
		if ($urandom_range(1) == 0) begin
			send_word(ACT_ALLOC, owner, UNITS_W'(n));
		end else begin
			run_units = ledger.pick_run_units();
			if (roll >= 12 && run_units > 0 && $urandom_range(99) < 60)
				n = run_units;
			send_word(ACT_FREE, TAG_W'($urandom_range(255)), UNITS_W'(n));
		end
		sender_pause();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero units, oversize, full table, tag-zero alloc, shared-tag clear
		send_word(ACT_ALLOC, 8'h01, 5'd0);
		send_word(ACT_FREE,  8'h00, 5'd0);
		send_word(ACT_ALLOC, 8'h33, 5'd17);
		send_word(ACT_ALLOC, 8'hCC, 5'd31);
		send_word(ACT_FREE,  8'hFF, 5'd31);
		send_word(ACT_FREE,  8'h00, 5'd16);
		send_word(ACT_ALLOC, 8'hFF, 5'd16);
		send_word(ACT_ALLOC, 8'h12, 5'd1);
		send_word(ACT_FREE,  8'h5A, 5'd16);
		send_word(ACT_ALLOC, 8'h00, 5'd4);
		send_word(ACT_ALLOC, 8'h80, 5'd1);
		send_word(ACT_ALLOC, 8'h7F, 5'd2);
		send_word(ACT_ALLOC, 8'h80, 5'd3);
		// run of three 0x80 found at slot 3, clear starts at slot 0 over the 0x7F pair
		send_word(ACT_FREE,  8'h00, 5'd3);
		send_word(ACT_FREE,  8'h00, 5'd5);
		send_word(ACT_ALLOC, 8'hAA, 5'd8);
		send_word(ACT_ALLOC, 8'h55, 5'd8);
		send_word(ACT_ALLOC, 8'h01, 5'd16);
		send_word(ACT_FREE,  8'h00, 5'd1);
		send_word(ACT_FREE,  8'h00, 5'd8);
		send_word(ACT_FREE,  8'h00, 5'd7);
		send_word(ACT_FREE,  8'h00, 5'd16);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 74;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 74;
				end
				default: begin
					send_idle_pct = 16;
					stall_pct = 16;
				end
			endcase
			repeat (215) random_request();
		end

		s_tvalid <= 1'b0;
		// let the monitor log the last accepted word before draining
		@(posedge clk);
		while (ledger.owed.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 4) @(posedge clk);
		if (ledger.errors == 0 && ledger.owed.size() == 0)
			$display("PASS first_fit_slot_allocator");
		else
			$display("FAIL first_fit_slot_allocator");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/ffsa_pkg.sv
src/ffsa_cell.sv
src/ffsa_ctrl.sv
src/first_fit_slot_allocator.sv
tb/tb_first_fit_slot_allocator.sv
